[src/b64e_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg: shared types and constants of the base64 stream encoder
// Group record, queue status, queue sizing and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int GQ_DEPTH = 2;
	localparam int GQ_PTR_W = (GQ_DEPTH > 1) ? $clog2(GQ_DEPTH) : 1;
	localparam int GQ_CNT_W = $clog2(GQ_DEPTH + 1);

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Byte count of a group as carried to the back end
	localparam logic [1:0] NB_ONE   = 2'd1;
	localparam logic [1:0] NB_TWO   = 2'd2;
	localparam logic [1:0] NB_THREE = 2'd3;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] nbytes;
		logic       last;
	} group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Map a 6-bit index onto the standard alphabet A-Z a-z 0-9 + /
	function automatic logic [7:0] enc_char(input logic [5:0] idx);
		logic [7:0] ch;
		if (idx < 6'd26) begin
			ch = 8'(idx) + 8'd65;
		end else if (idx < 6'd52) begin
			ch = 8'(idx) + 8'd71;
		end else if (idx < 6'd62) begin
			ch = 8'(idx) - 8'd4;
		end else if (idx == 6'd62) begin
			ch = 8'h2B;
		end else begin
			ch = 8'h2F;
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

[src/base64_stream_encoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder: streaming base64 encoder, standard alphabet
// Byte in, one ASCII character out per request, '=' padding on the last group.
// ----------------------------------------------------------------------------
// Output: the byte that closes a group writes it into the group queue,
//   and its first character is then loaded into the output register.
// Throughput: four characters per group, one per cycle unless the queue is
//   empty or out_ready holds the output; input takes one byte per cycle
//   until the two-entry group queue is full.
// Reset: arst_n clears fill count, queue pointers, character counter and valid.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       is_final,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            out_last
);

	b64e_pkg::q_stat_t q_stat;
	b64e_pkg::group_t  push_grp;
	b64e_pkg::group_t  head_grp;
	logic              grp_push;
	logic              grp_pop;

	// Front: gather bytes, close a group on the third byte or the final one
	b64e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.is_final  (is_final),
		.q_stat    (q_stat),
		.grp_push  (grp_push),
		.grp_data  (push_grp)
	);

	// Queue: decouple byte intake from character output
	b64e_grp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (grp_push),
		.push_data (push_grp),
		.pop       (grp_pop),
		.pop_data  (head_grp),
		.stat      (q_stat)
	);

	// Back: emit four characters per group, pad past the real bytes
	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.grp       (head_grp),
		.grp_pop   (grp_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.out_last  (out_last)
	);

	// Never push into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		grp_push |-> !q_stat.full)
		else $error("group pushed into full queue");

	// Never pop an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		grp_pop |-> !q_stat.empty)
		else $error("group popped from empty queue");

	// A popped group always leaves a valid character behind
	a_pop_gives_char: assert property (@(posedge clk) disable iff (!arst_n)
		grp_pop |=> out_valid)
		else $error("group popped without character output");

	// The last mark only rides on a character after a full four-char group
	a_last_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_last && out_valid |-> $past(grp_pop) || $stable(out_char))
		else $error("last mark without group end");

endmodule
`default_nettype wire

[src/b64e_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front: byte gatherer
// Collects raw bytes into groups of up to three and pushes each closed group.
// ----------------------------------------------------------------------------
module b64e_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              is_final,
	input  wire b64e_pkg::q_stat_t q_stat,
	output logic                   grp_push,
	output b64e_pkg::group_t       grp_data
);

	logic [7:0] pend0_q;
	logic [7:0] pend1_q;
	logic [1:0] fill_q;
	logic       accept;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		grp_push = 1'b0;
		grp_data = '{b0: data_byte, b1: 8'd0, b2: 8'd0,
			nbytes: b64e_pkg::NB_ONE, last: is_final};
		if (accept) begin
			priority if (fill_q == 2'd2) begin
				grp_push = 1'b1;
				grp_data = '{b0: pend0_q, b1: pend1_q, b2: data_byte,
					nbytes: b64e_pkg::NB_THREE, last: is_final};
			end else if (is_final && fill_q == 2'd1) begin
				grp_push = 1'b1;
				grp_data = '{b0: pend0_q, b1: data_byte, b2: 8'd0,
					nbytes: b64e_pkg::NB_TWO, last: 1'b1};
			end else if (is_final) begin
				grp_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else if (accept) begin
			if (grp_push) begin
				fill_q <= 2'd0;
			end else begin
				fill_q <= fill_q + 2'd1;
			end
		end
	end

	// hold pending bytes; slot chosen by fill count
	always_ff @(posedge clk) begin
		if (accept && !grp_push) begin
			if (fill_q == 2'd0) begin
				pend0_q <= data_byte;
			end else begin
				pend1_q <= data_byte;
			end
		end
	end

endmodule
`default_nettype wire

[src/b64e_grp_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_grp_fifo: group queue
// Short queue of closed groups between gatherer and character emitter.
// ----------------------------------------------------------------------------
module b64e_grp_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire b64e_pkg::group_t push_data,
	input  wire logic             pop,
	output b64e_pkg::group_t      pop_data,
	output b64e_pkg::q_stat_t     stat
);

	b64e_pkg::group_t                  mem_q [b64e_pkg::GQ_DEPTH];
	logic [b64e_pkg::GQ_PTR_W-1:0]     wr_ptr_q;
	logic [b64e_pkg::GQ_PTR_W-1:0]     rd_ptr_q;
	logic [b64e_pkg::GQ_CNT_W-1:0]     cnt_q;

	localparam logic [b64e_pkg::GQ_PTR_W-1:0] PTR_LAST =
		b64e_pkg::GQ_PTR_W'(b64e_pkg::GQ_DEPTH - 1);
	localparam logic [b64e_pkg::GQ_CNT_W-1:0] CNT_FULL =
		b64e_pkg::GQ_CNT_W'(b64e_pkg::GQ_DEPTH);

	assign stat.full  = (cnt_q == CNT_FULL);
	assign stat.empty = (cnt_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

[src/b64e_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back: character emitter
// Walks the head group one char per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module b64e_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire b64e_pkg::q_stat_t q_stat,
	input  wire b64e_pkg::group_t  grp,
	output logic                   grp_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_char,
	output logic                   out_last
);

	logic [1:0] pos_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       load;
	logic [5:0] idx;
	logic [7:0] next_char;

	assign load    = !q_stat.empty && (!valid_q || out_ready);
	assign grp_pop = load && (pos_q == 2'd3);

	always_comb begin
		unique case (pos_q)
			2'd0: idx = grp.b0[7:2];
			2'd1: idx = {grp.b0[1:0], grp.b1[7:4]};
			2'd2: idx = {grp.b1[3:0], grp.b2[7:6]};
			2'd3: idx = grp.b2[5:0];
			default: idx = grp.b2[5:0];
		endcase
		next_char = (pos_q <= grp.nbytes) ? b64e_pkg::enc_char(idx)
			: b64e_pkg::PAD_CHAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				pos_q   <= pos_q + 2'd1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= next_char;
			last_q <= grp.last && (pos_q == 2'd3);
		end
	end

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the base64 stream encoder
// Feeds messages of raw bytes through the valid/ready input and checks every
// output character and its last flag against a behavioral encoder model.
// ----------------------------------------------------------------------------
module tb;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_STALL   = 120;
	localparam int TAIL_CYCLES  = 12;

	// Standard alphabet, index 0 in the top byte
	localparam logic [511:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct {
		logic [7:0] data;
		logic       fin;
	} byte_req_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} b64_char_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       is_final  = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_char;
	logic       out_last;

	byte_req_t pending_requests[$];
	b64_char_t expected_chars[$];

	// Encoder model state: partial group and its fill count
	logic [7:0] grp_byte0 = 8'h00;
	logic [7:0] grp_byte1 = 8'h00;
	logic [1:0] grp_fill  = 2'd0;

	int fail_count    = 0;
	int cycle_count   = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int rx_hold_requests = 0;
	int rx_hold_served   = 0;
	int rx_hold_left     = 0;

	base64_stream_encoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.is_final  (is_final),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.out_last  (out_last)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Look up one alphabet character by its 6-bit index
	function automatic logic [7:0] alphabet_char(input logic [5:0] idx);
		return B64_ALPHABET[8 * (63 - int'(idx)) +: 8];
	endfunction

	// Split a group into four 6-bit indices, MSB first; pad past nb+1 characters
	task automatic emit_quartet(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [1:0] nb, input logic fin);
		logic [5:0] idx [4];
		b64_char_t  c;
		idx[0] = b0[7:2];
		idx[1] = {b0[1:0], b1[7:4]};
		idx[2] = {b1[3:0], b2[7:6]};
		idx[3] = b2[5:0];
		for (int k = 0; k < 4; k++) begin
			c.ch   = (k <= int'(nb)) ? alphabet_char(idx[k]) : b64e_pkg::PAD_CHAR;
			c.last = fin && (k == 3);
			expected_chars.push_back(c);
		end
	endtask

	// Advance the encoder model by one accepted byte
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		if (grp_fill == 2'd2) begin
			emit_quartet(grp_byte0, grp_byte1, b, b64e_pkg::NB_THREE, fin);
		end else if (fin) begin
			if (grp_fill == 2'd0) begin
				emit_quartet(b, 8'h00, 8'h00, b64e_pkg::NB_ONE, 1'b1);
			end else begin
				emit_quartet(grp_byte0, b, 8'h00, b64e_pkg::NB_TWO, 1'b1);
			end
		end else begin
			// Group still open: hold the byte, nothing comes out
			if (grp_fill == 2'd0) begin
				grp_byte0 = b;
			end else begin
				grp_byte1 = b;
			end
			grp_fill = grp_fill + 2'd1;
			return;
		end
		grp_byte0 = 8'h00;
		grp_byte1 = 8'h00;
		grp_fill  = 2'd0;
	endtask

	// ------------------------------------------------------------------------
	// Driver: present the next request when the channel is free. A request
	// that is already up stays up, unchanged, until the encoder takes it.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_requests
		byte_req_t req;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			data_byte <= 8'h00;
			is_final  <= 1'b0;
		end else begin
			// Accepted request: predict its characters right away
			if (in_valid && in_ready) begin
				encode_byte(data_byte, is_final);
			end
			if (!in_valid || in_ready) begin
				if (pending_requests.size() != 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					req = pending_requests.pop_front();
					in_valid  <= 1'b1;
					data_byte <= req.data;
					is_final  <= req.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check each accepted character against the oldest prediction
	// and drive out_ready, with random stalls and the occasional long hold.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : check_chars
		b64_char_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected char: expected none, actual %h last %b",
						$time, out_char, out_last);
				end else begin
					want = expected_chars.pop_front();
					if (out_char !== want.ch) begin
						fail_count++;
						$display("%0t: out_char mismatch: expected %h, actual %h",
							$time, want.ch, out_char);
					end
					if (out_last !== want.last) begin
						fail_count++;
						$display("%0t: out_last mismatch: expected %b, actual %b",
							$time, want.last, out_last);
					end
				end
			end
			// Load a long hold when one is asked for, then count it down
			if (rx_hold_served != rx_hold_requests) begin
				rx_hold_served = rx_hold_requests;
				rx_hold_left   = LONG_STALL;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d chars still expected", $time,
				expected_chars.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic fin);
		byte_req_t req;
		req.data = b;
		req.fin  = fin;
		pending_requests.push_back(req);
	endtask

	task automatic push_random_message(input int len);
		for (int i = 0; i < len; i++) begin
			push_byte(8'($urandom_range(255)), i == len - 1);
		end
	endtask

	// Wait until the sender has nothing left and every character has arrived
	task automatic wait_drained();
		while (pending_requests.size() != 0 || in_valid || expected_chars.size() != 0)
			@(negedge clk);
	endtask

	// Push random messages until about n bytes are queued; mostly short ones
	task automatic push_random_bytes(input int n);
		int sent;
		int len;
		sent = 0;
		while (sent < n) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			push_random_message(len);
			sent += len;
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		send_idle_pct = 19;
		recv_idle_pct = 46;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: one-, two- and three-byte tails, extreme bytes, '+' and '/'
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1);
		push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
		push_byte(8'hFB, 1'b0); push_byte(8'hEF, 1'b0); push_byte(8'hBE, 1'b1);
		push_byte(8'h4D, 1'b0); push_byte(8'h61, 1'b0); push_byte(8'h6E, 1'b1);
		push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'h03, 1'b0);
		push_byte(8'h04, 1'b1);
		push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0); push_byte(8'h80, 1'b1);
		// Sender pause: hold off until every predicted character is out
		wait_drained();

		// Phase one: long receiver hold while the sender keeps offering bytes
		rx_hold_requests++;
		push_random_message(24);
		push_random_bytes(60);
		wait_drained();

		// Phase two: roles swapped
		send_idle_pct = 46;
		recv_idle_pct = 19;
		push_random_bytes(70);
		wait_drained();

		// Phase three: no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_random_bytes(70);
		wait_drained();

		// Let any stray character show before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0) begin
			fail_count++;
			$display("%0t: %0d chars never arrived", $time, expected_chars.size());
		end
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[filelist.f]
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_grp_fifo.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
tb/tb.sv
